### rtl/lkvc_pkg.sv
// Package for the LRU key-value cache.
// Holds sizes, register codes and the request and response types.
// No dependencies.
package lkvc_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 32;
    localparam int RANK_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int COUNT_BITS = $clog2(ENTRIES + 1);
    localparam int CAP_BITS   = 5;
    localparam int ADDR_BITS  = 3;
    localparam int DATA_BITS  = 32;

    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

    // Register index, decoded from paddr[2].
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_req;

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] value;
    } t_rsp;

endpackage

### rtl/lru_key_value_cache_top.sv
// LRU key-value cache top level: input register, entry store, result register.
// An accepted transaction passes through the input register and then the result register.
// Throughput: one transaction per cycle; busy is always low.
// The entry store is updated in the cycle after the input register.
// Synchronous active-low reset empties the cache and sets capacity to 16.
// Depends on lkvc_pkg, lkvc_regs and lkvc_store.
module lru_key_value_cache_top
    import lkvc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_operation,
    input  logic [KEY_BITS-1:0]   i_lookup_key,
    input  logic [VALUE_BITS-1:0] i_store_value,
    output logic                  o_strobe,
    output logic                  o_hit,
    output logic [VALUE_BITS-1:0] o_read_value,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [DATA_BITS-1:0]  pwdata,
    output logic [DATA_BITS-1:0]  prdata,
    output logic                  pready
);

    logic                r_req_valid;
    t_req                r_req;
    logic                r_strobe;
    t_rsp                r_rsp;
    t_rsp                rsp;
    logic [CAP_BITS-1:0] capacity;
    logic                accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    lkvc_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (capacity)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_req_valid <= accept;
            r_strobe    <= r_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.op    <= t_op'(i_operation);
            r_req.key   <= i_lookup_key;
            r_req.value <= i_store_value;
        end
        if (r_req_valid) begin
            r_rsp <= rsp;
        end
    end

    lkvc_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (r_req_valid),
        .i_req       (r_req),
        .i_capacity  (capacity),
        .o_rsp       (rsp)
    );

    assign o_strobe     = r_strobe;
    assign o_hit        = r_rsp.hit;
    assign o_read_value = r_rsp.value;

endmodule

### rtl/lkvc_regs.sv
// Configuration register file with an APB-style port.
// Holds the capacity register. Depends on lkvc_pkg.
module lkvc_regs
    import lkvc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    output logic [CAP_BITS-1:0]  o_capacity
);

    logic [CAP_BITS-1:0] r_capacity;
    logic [CAP_BITS-1:0] n_capacity;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        n_capacity = r_capacity;
        if (wr_en && (paddr[2] == REG_CAPACITY)) begin
            n_capacity = pwdata[CAP_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else begin
            r_capacity <= n_capacity;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_CAPACITY) begin
            prdata = DATA_BITS'(r_capacity);
        end
    end

    assign o_capacity = r_capacity;

endmodule

### rtl/lkvc_store.sv
// Entry store of the LRU cache: valid bits, keys, values and recency ranks.
// Parallel key compare, rank update, eviction and insertion are combinational; the new state is registered.
// Depends on lkvc_pkg.
module lkvc_store
    import lkvc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  t_req                i_req,
    input  logic [CAP_BITS-1:0] i_capacity,
    output t_rsp                o_rsp
);

    logic [ENTRIES-1:0]    r_valid;
    logic [KEY_BITS-1:0]   r_key   [ENTRIES];
    logic [VALUE_BITS-1:0] r_value [ENTRIES];
    logic [RANK_BITS-1:0]  r_rank  [ENTRIES];

    logic [ENTRIES-1:0]    n_valid;
    logic [VALUE_BITS-1:0] n_value [ENTRIES];
    logic [RANK_BITS-1:0]  n_rank  [ENTRIES];

    logic [ENTRIES-1:0]    match;
    logic [ENTRIES-1:0]    evict;
    logic [ENTRIES-1:0]    insert;
    logic [ENTRIES-1:0]    kept;
    logic                  any_match;
    logic [RANK_BITS-1:0]  found_rank;
    logic [VALUE_BITS-1:0] found_value;
    logic [COUNT_BITS-1:0] count;
    logic [CAP_BITS-1:0]   eff_cap;
    logic [CAP_BITS-1:0]   cap_m1;
    logic                  full;
    logic                  put_miss;
    logic                  taken;

    always_comb begin
        match       = '0;
        found_rank  = '0;
        found_value = '0;
        count       = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i]    = r_valid[i] && (r_key[i] == i_req.key);
            count       = count + COUNT_BITS'(r_valid[i]);
            found_rank  = found_rank | (r_rank[i] & {RANK_BITS{match[i]}});
            found_value = found_value | (r_value[i] & {VALUE_BITS{match[i]}});
        end
        any_match = |match;
    end

    always_comb begin
        if (i_capacity == '0) begin
            eff_cap = CAP_BITS'(1);
        end else if (i_capacity > CAP_BITS'(ENTRIES)) begin
            eff_cap = CAP_BITS'(ENTRIES);
        end else begin
            eff_cap = i_capacity;
        end
        cap_m1   = eff_cap - CAP_BITS'(1);
        full     = CAP_BITS'(count) >= eff_cap;
        put_miss = i_req_valid && (i_req.op == OP_PUT) && !any_match;
    end

    always_comb begin
        taken = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            evict[i]  = put_miss && full && r_valid[i]
                        && (CAP_BITS'(r_rank[i]) >= cap_m1);
            kept[i]   = r_valid[i] && !evict[i];
            insert[i] = put_miss && !kept[i] && !taken;
            taken     = taken || !kept[i];
        end
    end

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            n_valid[i] = r_valid[i];
            n_value[i] = r_value[i];
            n_rank[i]  = r_rank[i];
            if (i_req_valid && any_match) begin
                if (match[i]) begin
                    n_rank[i] = '0;
                    if (i_req.op == OP_PUT) begin
                        n_value[i] = i_req.value;
                    end
                end else if (r_valid[i] && (r_rank[i] < found_rank)) begin
                    n_rank[i] = r_rank[i] + RANK_BITS'(1);
                end
            end else if (put_miss) begin
                n_valid[i] = kept[i] || insert[i];
                if (insert[i]) begin
                    n_rank[i]  = '0;
                    n_value[i] = i_req.value;
                end else if (kept[i]) begin
                    n_rank[i] = r_rank[i] + RANK_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            r_value[i] <= n_value[i];
            r_rank[i]  <= n_rank[i];
            if (insert[i]) begin
                r_key[i] <= i_req.key;
            end
        end
    end

    always_comb begin
        o_rsp.hit   = (i_req.op == OP_GET) && any_match;
        o_rsp.value = o_rsp.hit ? found_value : '0;
    end

endmodule

### rtl/lkvc_checker.sv
// Port-level checker for the LRU key-value cache, bound to the top level.
// Depends on lkvc_pkg and lru_key_value_cache_top.
module lkvc_checker
    import lkvc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  i_operation,
    input logic                  o_strobe,
    input logic                  o_hit,
    input logic [VALUE_BITS-1:0] o_read_value
);

    // Every accepted transaction produces a result on o_strobe.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> ##1 o_strobe)
        else $error("accepted transaction produced no result");

    // A result appears only for an accepted transaction.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 2))
        else $error("result without an accepted transaction");

    // A miss or a put returns zero data.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_hit |-> o_read_value == '0)
        else $error("nonzero data on a miss or a put");

    // Only a get can report a hit.
    a_hit_is_get: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_hit |-> $past(i_operation, 2) == OP_GET)
        else $error("hit reported for a put");

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_operation  (i_operation),
    .o_strobe     (o_strobe),
    .o_hit        (o_hit),
    .o_read_value (o_read_value)
);

### bench/testbench.sv
// Self-checking testbench for lru_key_value_cache_top: directed and random get/put traffic.
// Each transaction is predicted by an LRU store model in the bench and checked against the DUT.
// Depends on lkvc_pkg and the lru_key_value_cache_top RTL.
module testbench;
    import lkvc_pkg::*;

    localparam logic [ADDR_BITS-1:0] CAPACITY_ADDR = ADDR_BITS'({REG_CAPACITY, 2'b00});
    localparam int POOL_SIZE = 32;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_operation;
    logic [KEY_BITS-1:0]   i_lookup_key;
    logic [VALUE_BITS-1:0] i_store_value;
    logic                  o_strobe;
    logic                  o_hit;
    logic [VALUE_BITS-1:0] o_read_value;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_BITS-1:0]  paddr;
    logic [DATA_BITS-1:0]  pwdata;
    logic [DATA_BITS-1:0]  prdata;
    logic                  pready;

    logic                  line_valid [ENTRIES];
    logic [KEY_BITS-1:0]   line_key   [ENTRIES];
    logic [VALUE_BITS-1:0] line_value [ENTRIES];
    int unsigned           line_rank  [ENTRIES];
    logic [CAP_BITS-1:0]   capacity_reg;

    logic [KEY_BITS-1:0]   key_pool [POOL_SIZE];
    t_rsp                  pending_responses [$];
    int                    mismatch_count;
    int                    idle_pct;

    lru_key_value_cache_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_lookup_key  (i_lookup_key),
        .i_store_value (i_store_value),
        .o_strobe      (o_strobe),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #100000;
        $display("lru_key_value_cache_top regression: fail");
        $finish;
    end

    function automatic t_rsp lru_lookup_and_update(t_op op, logic [KEY_BITS-1:0] key,
                                                   logic [VALUE_BITS-1:0] value);
        t_rsp        rsp;
        int          found;
        int unsigned held;
        int unsigned cap;
        int unsigned old_rank;
        logic        placed;
        rsp = '0;
        found = -1;
        held = 0;
        placed = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (line_valid[i]) begin
                held++;
                if (found < 0 && line_key[i] == key) found = i;
            end
        end
        if (found >= 0) begin
            if (op == OP_GET) begin
                rsp.hit = 1'b1;
                rsp.value = line_value[found];
            end else begin
                line_value[found] = value;
            end
            old_rank = line_rank[found];
            for (int i = 0; i < ENTRIES; i++) begin
                if (line_valid[i] && line_rank[i] < old_rank) line_rank[i]++;
            end
            line_rank[found] = 0;
            return rsp;
        end
        if (op == OP_GET) return rsp;
        if (capacity_reg == 0) cap = 1;
        else if (capacity_reg > ENTRIES) cap = ENTRIES;
        else cap = capacity_reg;
        if (held >= cap) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (line_valid[i] && line_rank[i] >= cap - 1) line_valid[i] = 1'b0;
            end
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (line_valid[i]) line_rank[i]++;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (!placed && !line_valid[i]) begin
                line_valid[i] = 1'b1;
                line_key[i] = key;
                line_value[i] = value;
                line_rank[i] = 0;
                placed = 1'b1;
            end
        end
        return rsp;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] expected, logic [31:0] actual);
        $display("mismatch at %0t: %s expected %h got %h", $realtime, what, expected, actual);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : check_responses
        t_rsp want;
        if (i_rst_n && o_strobe) begin
            if (pending_responses.size() == 0) begin
                report_mismatch("unexpected result, read_value", 32'h0, o_read_value);
            end else begin
                want = pending_responses.pop_front();
                if (o_hit !== want.hit) report_mismatch("hit", 32'(want.hit), 32'(o_hit));
                if (o_read_value !== want.value) begin
                    report_mismatch("read_value", want.value, o_read_value);
                end
            end
        end
    end

    task automatic issue_access(t_op op, logic [KEY_BITS-1:0] key, logic [VALUE_BITS-1:0] value);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_operation <= op;
        i_lookup_key <= key;
        i_store_value <= value;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_responses.push_back(lru_lookup_and_update(op, key, value));
    endtask

    task automatic wait_until_idle();
        start <= 1'b0;
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [DATA_BITS-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CAPACITY_ADDR;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        capacity_reg = data[CAP_BITS-1:0];
    endtask

    task automatic test_empty_and_extremes();
        issue_access(OP_GET, 16'h0000, 32'h0000_0000);
        issue_access(OP_PUT, 16'h0000, 32'h0000_0000);
        issue_access(OP_PUT, 16'hFFFF, 32'hFFFF_FFFF);
        issue_access(OP_GET, 16'hFFFF, 32'h1234_5678);
        issue_access(OP_GET, 16'h0000, 32'hFFFF_FFFF);
        issue_access(OP_GET, 16'h0001, 32'h0000_0000);
        issue_access(OP_PUT, 16'h0000, 32'hA5A5_5A5A);
        issue_access(OP_GET, 16'h0000, 32'h0000_0000);
    endtask

    task automatic test_eviction_order();
        wait_until_idle();
        write_capacity(32'd2);
        issue_access(OP_PUT, 16'h0010, 32'h0000_1010);
        issue_access(OP_PUT, 16'h0020, 32'h0000_2020);
        issue_access(OP_GET, 16'h0010, 32'h0);
        issue_access(OP_PUT, 16'h0030, 32'h0000_3030);
        issue_access(OP_GET, 16'h0020, 32'h0);
        issue_access(OP_GET, 16'h0010, 32'h0);
    endtask

    task automatic test_capacity_extremes();
        wait_until_idle();
        write_capacity(32'd0);
        issue_access(OP_PUT, 16'h1234, 32'h0000_0001);
        issue_access(OP_PUT, 16'h4321, 32'h0000_0002);
        issue_access(OP_GET, 16'h1234, 32'h0);
        issue_access(OP_GET, 16'h4321, 32'h0);
        wait_until_idle();
        write_capacity(32'hFFFF_FFFF);
        issue_access(OP_PUT, 16'h5555, 32'h5555_AAAA);
        issue_access(OP_GET, 16'h4321, 32'h0);
    endtask

    task automatic test_capacity_shrink();
        wait_until_idle();
        write_capacity(32'd16);
        for (int i = 1; i <= 4; i++) begin
            issue_access(OP_PUT, KEY_BITS'(16'h0100 + i), VALUE_BITS'(i));
        end
        wait_until_idle();
        write_capacity(32'hFFFF_FFE2);
        issue_access(OP_GET, 16'h0101, 32'h0);
        issue_access(OP_PUT, 16'h0200, 32'h0000_0200);
        issue_access(OP_GET, 16'h0104, 32'h0);
        issue_access(OP_GET, 16'h0101, 32'h0);
    endtask

    task automatic test_random_traffic(int items, int key_span, int idle);
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        t_op                   op;
        idle_pct = idle;
        for (int n = 0; n < items; n++) begin
            op = ($urandom_range(1) == 1) ? OP_PUT : OP_GET;
            if ($urandom_range(99) < 15) key = KEY_BITS'($urandom);
            else key = key_pool[$urandom_range(key_span - 1)];
            case ($urandom_range(9))
                0: value = '0;
                1: value = '1;
                default: value = VALUE_BITS'($urandom);
            endcase
            issue_access(op, key, value);
        end
        idle_pct = 0;
    endtask

    task automatic test_random_phase(logic [DATA_BITS-1:0] cap, int items, int key_span, int idle);
        wait_until_idle();
        write_capacity(cap);
        test_random_traffic(items, key_span, idle);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_operation <= OP_GET;
        i_lookup_key <= '0;
        i_store_value <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        mismatch_count = 0;
        idle_pct = 0;
        capacity_reg = CAP_RESET;
        for (int i = 0; i < ENTRIES; i++) begin
            line_valid[i] = 1'b0;
            line_key[i] = '0;
            line_value[i] = '0;
            line_rank[i] = 0;
        end
        for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = KEY_BITS'($urandom);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_extremes();
        test_eviction_order();
        test_capacity_extremes();
        test_capacity_shrink();

        test_random_phase(32'd16, 200, 24, 0);
        test_random_phase(32'd1, 100, 4, 76);
        test_random_phase(32'd31, 150, 28, 22);
        test_random_phase(32'd5, 150, 9, 0);
        test_random_phase(32'd0, 50, 3, 76);
        test_random_phase(DATA_BITS'($urandom_range(16, 1)), 100, 20, 22);
        test_random_phase(32'd16, 60, 20, 0);
        test_random_phase(32'd3, 40, 8, 76);

        wait_until_idle();
        if (mismatch_count == 0) begin
            $display("lru_key_value_cache_top regression: pass");
        end else begin
            $display("lru_key_value_cache_top regression: fail");
        end
        $finish;
    end

endmodule
